FILE: rtl/call_stack_function_profiler_core_assert.svh
// ----------------------------------------------------------------------------
// Call stack function profiler assertion macros
// Implication checks used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CALL_STACK_FUNCTION_PROFILER_CORE_ASSERT_SVH
`define CALL_STACK_FUNCTION_PROFILER_CORE_ASSERT_SVH

// same-cycle implication, skipped while reset is high
`define CSFP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csfp: implication check failed");

// next-cycle implication, skipped while reset is high
`define CSFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csfp: next-cycle check failed");

// next-cycle implication, checked through reset as well
`define CSFP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("csfp: reset check failed");

`endif

FILE: rtl/csfp_pkg.sv
// ----------------------------------------------------------------------------
// Call stack function profiler package
// Sizes, opcodes, sequencer states and storage entry types.
// ----------------------------------------------------------------------------
package csfp_pkg;

   localparam int FUNC_COUNT  = 256;
   localparam int STACK_DEPTH = 64;

   localparam int ID_W       = 8;
   localparam int FUNC_IDX_W = $clog2(FUNC_COUNT);
   localparam int STK_ADDR_W = $clog2(STACK_DEPTH);
   localparam int LVL_W      = $clog2(STACK_DEPTH + 1);
   localparam int HITS_W     = 32;
   localparam int VAL_W      = 64;
   localparam int DIV_STEPS  = VAL_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam logic OP_CALL   = 1'b0;
   localparam logic OP_RETURN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALL_RD,
      ST_STK_RD,
      ST_TBL_RD,
      ST_DIV,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [HITS_W-1:0] hits;
      logic [VAL_W-1:0]  time_sum;
      logic [VAL_W-1:0]  avg;
      logic [VAL_W-1:0]  instr_sum;
   } tbl_entry_type;

   typedef struct packed {
      logic [FUNC_IDX_W-1:0] func;
      logic [VAL_W-1:0]      start_time;
      logic [VAL_W-1:0]      start_instr;
   } frame_type;

   // table index of a function id (FUNC_COUNT is a power of two)
   function automatic logic [FUNC_IDX_W-1:0] func_index(input logic [ID_W-1:0] id);
      logic [FUNC_IDX_W+ID_W-1:0] wide;
      wide = {{FUNC_IDX_W{1'b0}}, id};
      return wide[FUNC_IDX_W-1:0];
   endfunction

endpackage

FILE: rtl/call_stack_function_profiler_core.sv
// ----------------------------------------------------------------------------
// Call stack function profiler core
// Per-function hit, time and instruction statistics kept over a call stack.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one call or return event per request, with a
//   timestamp and an instruction counter. Result channel (rsp_*): exactly one
//   result per request, in request order, with the statistics of the touched
//   function and the total call count.
//   A call reads its table entry (CALL_RD) and then finishes (DONE). A return
//   reads the frame stack (STK_RD) and the table (TBL_RD), runs the bit-serial
//   64 by 32 divider that computes the average time (DIV) and writes the
//   table (WRITE); a return on an empty stack goes straight to DONE. One
//   request is in work at a time: req_ready is high only in idle, so a new
//   request waits for the last to finish, but is taken while a result waits.
//   Frame stack and statistics table are memories with registered reads; one
//   valid bit per table entry lets reset clear all statistics without writing the table.
//   When the receiver stalls, the finished result holds in the output
//   register and the next request waits in its final step until it drains.
// ----------------------------------------------------------------------------
module call_stack_function_profiler_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_operation,
   input  logic [csfp_pkg::ID_W-1:0]  req_func_id,
   input  logic [csfp_pkg::VAL_W-1:0] req_timestamp_ns,
   input  logic [csfp_pkg::VAL_W-1:0] req_instr_count,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [csfp_pkg::ID_W-1:0]  rsp_entry_id,
   output logic [csfp_pkg::HITS_W-1:0] rsp_hit_total,
   output logic [csfp_pkg::VAL_W-1:0] rsp_time_total,
   output logic [csfp_pkg::VAL_W-1:0] rsp_time_average,
   output logic [csfp_pkg::VAL_W-1:0] rsp_instr_total,
   output logic [csfp_pkg::HITS_W-1:0] rsp_all_calls,
   output logic                       rsp_empty_return,
   output logic                       rsp_stack_full
);
   import csfp_pkg::*;

   state_type             state_ff, state_in;
   logic                  op_ff, op_in;
   logic [FUNC_IDX_W-1:0] idx_ff, idx_in;
   logic [VAL_W-1:0]      ts_ff, ts_in;
   logic [VAL_W-1:0]      ic_ff, ic_in;
   logic [LVL_W-1:0]      level_ff, level_in;
   logic [HITS_W-1:0]     calls_ff, calls_in;
   logic [HITS_W-1:0]     hits_ff, hits_in;
   logic [VAL_W-1:0]      time_ff, time_in;
   logic [VAL_W-1:0]      instr_ff, instr_in;
   logic [VAL_W-1:0]      quo_ff, quo_in;
   logic [HITS_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  empty_ff, empty_in;
   logic                  full_ff, full_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]       rsp_id_ff;
   logic [HITS_W-1:0]     rsp_hits_ff;
   logic [VAL_W-1:0]      rsp_time_ff;
   logic [VAL_W-1:0]      rsp_avg_ff;
   logic [VAL_W-1:0]      rsp_instr_ff;
   logic [HITS_W-1:0]     rsp_calls_ff;
   logic                  rsp_empty_ff;
   logic                  rsp_full_ff;

   tbl_entry_type         tbl_mem [FUNC_COUNT];
   logic [FUNC_COUNT-1:0] tbl_valid_ff;
   tbl_entry_type         tbl_rd_ff;
   logic                  tbl_rd_valid_ff;
   tbl_entry_type         tbl_entry;
   tbl_entry_type         tbl_wr_data;
   logic [FUNC_IDX_W-1:0] tbl_rd_addr;
   logic                  tbl_we;

   frame_type             stk_mem [STACK_DEPTH];
   frame_type             stk_rd_ff;
   frame_type             stk_wr_data;
   logic [STK_ADDR_W-1:0] stk_rd_addr;
   logic [STK_ADDR_W-1:0] stk_wr_addr;
   logic                  stk_we;

   logic                  accept;
   logic                  rsp_load;
   logic                  level_zero;
   logic                  level_room;
   logic [VAL_W-1:0]      time_sum;
   logic [HITS_W:0]       rem_shift;
   logic                  rem_ge;

   assign accept     = req_valid && req_ready;
   assign level_zero = (level_ff == '0);
   assign level_room = (level_ff < LVL_W'(STACK_DEPTH));
   assign tbl_entry  = tbl_rd_valid_ff ? tbl_rd_ff : '0;
   assign time_sum   = tbl_entry.time_sum + ts_ff;
   assign rem_shift  = {rem_ff, quo_ff[VAL_W-1]};
   assign rem_ge     = (rem_shift >= {1'b0, hits_ff});

   assign stk_rd_addr = STK_ADDR_W'(level_ff - LVL_W'(1));
   assign stk_wr_addr = level_ff[STK_ADDR_W-1:0];
   assign stk_wr_data = '{func: idx_ff, start_time: ts_ff, start_instr: ic_ff};
   assign tbl_rd_addr = (state_ff == ST_IDLE) ? func_index(req_func_id) : stk_rd_ff.func;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_CALL) begin
                  state_in = ST_CALL_RD;
               end else if (level_zero) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_STK_RD;
               end
            end
         end
         ST_CALL_RD: state_in = ST_DONE;
         ST_STK_RD:  state_in = ST_TBL_RD;
         ST_TBL_RD:  state_in = (tbl_entry.hits == '0) ? ST_WRITE : ST_DIV;
         ST_DIV:     state_in = (cnt_ff == '0) ? ST_WRITE : ST_DIV;
         ST_WRITE:   state_in = ST_DONE;
         ST_DONE:    state_in = rsp_load ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      tbl_we      = (state_ff == ST_CALL_RD) || (state_ff == ST_WRITE);
      stk_we      = (state_ff == ST_CALL_RD) && level_room;
      rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
      tbl_wr_data = '{hits: hits_ff, time_sum: time_ff, avg: quo_ff, instr_sum: instr_ff};
      if (state_ff == ST_CALL_RD) begin
         tbl_wr_data      = tbl_entry;
         tbl_wr_data.hits = tbl_entry.hits + HITS_W'(1);
      end
   end

   // datapath
   always_comb begin
      op_in    = op_ff;
      idx_in   = idx_ff;
      ts_in    = ts_ff;
      ic_in    = ic_ff;
      level_in = level_ff;
      calls_in = calls_ff;
      hits_in  = hits_ff;
      time_in  = time_ff;
      instr_in = instr_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      empty_in = empty_ff;
      full_in  = full_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_operation;
               idx_in   = func_index(req_func_id);
               ts_in    = req_timestamp_ns;
               ic_in    = req_instr_count;
               empty_in = (req_operation == OP_RETURN) && level_zero;
               full_in  = 1'b0;
            end
         end
         ST_CALL_RD: begin
            hits_in  = tbl_entry.hits + HITS_W'(1);
            time_in  = tbl_entry.time_sum;
            quo_in   = tbl_entry.avg;
            instr_in = tbl_entry.instr_sum;
            calls_in = calls_ff + HITS_W'(1);
            if (level_room) begin
               level_in = level_ff + LVL_W'(1);
            end else begin
               full_in = 1'b1;
            end
         end
         ST_STK_RD: begin
            idx_in = stk_rd_ff.func;
            ts_in  = ts_ff - stk_rd_ff.start_time;
            ic_in  = ic_ff - stk_rd_ff.start_instr;
         end
         ST_TBL_RD: begin
            hits_in  = tbl_entry.hits;
            time_in  = time_sum;
            instr_in = tbl_entry.instr_sum + ic_ff;
            rem_in   = '0;
            cnt_in   = CNT_W'(DIV_STEPS - 1);
            quo_in   = (tbl_entry.hits == '0) ? '1 : time_sum;
         end
         ST_DIV: begin
            rem_in = rem_ge ? HITS_W'(rem_shift - {1'b0, hits_ff}) : rem_shift[HITS_W-1:0];
            quo_in = {quo_ff[VAL_W-2:0], rem_ge};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         ST_WRITE: begin
            level_in = level_ff - LVL_W'(1);
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         calls_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tbl_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         calls_ff     <= calls_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tbl_we) begin
            tbl_valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      idx_ff   <= idx_in;
      ts_ff    <= ts_in;
      ic_ff    <= ic_in;
      hits_ff  <= hits_in;
      time_ff  <= time_in;
      instr_ff <= instr_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      empty_ff <= empty_in;
      full_ff  <= full_in;
      if (rsp_load) begin
         rsp_id_ff    <= empty_ff ? '0 : ID_W'(idx_ff);
         rsp_hits_ff  <= empty_ff ? '0 : hits_ff;
         rsp_time_ff  <= empty_ff ? '0 : time_ff;
         rsp_avg_ff   <= empty_ff ? '0 : quo_ff;
         rsp_instr_ff <= empty_ff ? '0 : instr_ff;
         rsp_calls_ff <= calls_ff;
         rsp_empty_ff <= empty_ff;
         rsp_full_ff  <= full_ff && (op_ff == OP_CALL);
      end
   end

   // statistics table
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[idx_ff] <= tbl_wr_data;
      end
      tbl_rd_ff       <= tbl_mem[tbl_rd_addr];
      tbl_rd_valid_ff <= tbl_valid_ff[tbl_rd_addr];
   end

   // frame stack
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wr_addr] <= stk_wr_data;
      end
      stk_rd_ff <= stk_mem[stk_rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_id     = rsp_id_ff;
   assign rsp_hit_total    = rsp_hits_ff;
   assign rsp_time_total   = rsp_time_ff;
   assign rsp_time_average = rsp_avg_ff;
   assign rsp_instr_total  = rsp_instr_ff;
   assign rsp_all_calls    = rsp_calls_ff;
   assign rsp_empty_return = rsp_empty_ff;
   assign rsp_stack_full   = rsp_full_ff;

endmodule

FILE: rtl/csfp_checker.sv
// ----------------------------------------------------------------------------
// Call stack function profiler port checker
// Port-level checks on the profiler core, attached by bind.
// ----------------------------------------------------------------------------
`include "call_stack_function_profiler_core_assert.svh"

module csfp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [csfp_pkg::ID_W-1:0]   rsp_entry_id,
   input logic [csfp_pkg::HITS_W-1:0] rsp_hit_total,
   input logic [csfp_pkg::VAL_W-1:0]  rsp_time_total,
   input logic                        rsp_empty_return,
   input logic                        rsp_stack_full
);
   import csfp_pkg::*;

   `CSFP_ASSERT_NEXT_ALWAYS(a_reset_drops_rsp, clock, reset, !rsp_valid)
   `CSFP_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CSFP_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `CSFP_ASSERT_IMPLY(a_flags_exclusive, clock, reset, rsp_valid, !(rsp_empty_return && rsp_stack_full))
   `CSFP_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && rsp_empty_return, (rsp_entry_id == '0) && (rsp_hit_total == '0) && (rsp_time_total == '0))

endmodule

bind call_stack_function_profiler_core csfp_checker u_csfp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_entry_id     (rsp_entry_id),
   .rsp_hit_total    (rsp_hit_total),
   .rsp_time_total   (rsp_time_total),
   .rsp_empty_return (rsp_empty_return),
   .rsp_stack_full   (rsp_stack_full)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Call stack function profiler core testbench
// Drives call and return events through the request channel, mirrors the
// frame stack and the per-function statistics in a local model, and compares
// every result field with the prediction, under random request and result
// stalls and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import csfp_pkg::*;

   localparam int LONG_HOLD   = 400;
   localparam int IDLE_LIMIT  = 3000;
   localparam int TAIL_CYCLES = 80;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [ID_W-1:0]   entry_id;
      logic [HITS_W-1:0] hit_total;
      logic [VAL_W-1:0]  time_total;
      logic [VAL_W-1:0]  time_average;
      logic [VAL_W-1:0]  instr_total;
      logic [HITS_W-1:0] all_calls;
      logic              empty_return;
      logic              stack_full;
   } profile_result_type;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic               req_operation    = OP_CALL;
   logic [ID_W-1:0]    req_func_id      = '0;
   logic [VAL_W-1:0]   req_timestamp_ns = '0;
   logic [VAL_W-1:0]   req_instr_count  = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic [ID_W-1:0]    rsp_entry_id;
   logic [HITS_W-1:0]  rsp_hit_total;
   logic [VAL_W-1:0]   rsp_time_total;
   logic [VAL_W-1:0]   rsp_time_average;
   logic [VAL_W-1:0]   rsp_instr_total;
   logic [HITS_W-1:0]  rsp_all_calls;
   logic               rsp_empty_return;
   logic               rsp_stack_full;

   call_stack_function_profiler_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_func_id      (req_func_id),
      .req_timestamp_ns (req_timestamp_ns),
      .req_instr_count  (req_instr_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_entry_id     (rsp_entry_id),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_time_total   (rsp_time_total),
      .rsp_time_average (rsp_time_average),
      .rsp_instr_total  (rsp_instr_total),
      .rsp_all_calls    (rsp_all_calls),
      .rsp_empty_return (rsp_empty_return),
      .rsp_stack_full   (rsp_stack_full)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // call stack and statistics mirror
   logic [FUNC_IDX_W-1:0] frame_fn     [STACK_DEPTH];
   logic [VAL_W-1:0]      frame_t0     [STACK_DEPTH];
   logic [VAL_W-1:0]      frame_i0     [STACK_DEPTH];
   int unsigned           stack_level  = 0;
   logic [HITS_W-1:0]     hit_count    [FUNC_COUNT] = '{default: '0};
   logic [VAL_W-1:0]      elapsed_sum  [FUNC_COUNT] = '{default: '0};
   logic [VAL_W-1:0]      avg_elapsed  [FUNC_COUNT] = '{default: '0};
   logic [VAL_W-1:0]      instr_sum    [FUNC_COUNT] = '{default: '0};
   logic [HITS_W-1:0]     total_calls  = '0;

   profile_result_type pending_results[$];
   int              mismatch_count  = 0;
   int              idle_cycles     = 0;
   int              burst_left      = 0;
   int              hold_requests   = 0;
   logic [VAL_W-1:0] now_ns         = '0;
   logic [VAL_W-1:0] now_instr      = '0;

   function automatic profile_result_type profile_event(input logic op,
                                                        input logic [ID_W-1:0] fid,
                                                        input logic [VAL_W-1:0] ts,
                                                        input logic [VAL_W-1:0] ic);
      profile_result_type r;
      int unsigned        idx;
      int unsigned        top;
      r   = '0;
      idx = 0;
      if (op == OP_CALL) begin
         idx = fid % FUNC_COUNT;
         hit_count[idx] += 1;
         total_calls    += 1;
         if (stack_level < STACK_DEPTH) begin
            frame_fn[stack_level] = FUNC_IDX_W'(idx);
            frame_t0[stack_level] = ts;
            frame_i0[stack_level] = ic;
            stack_level++;
         end else begin
            r.stack_full = 1'b1;
         end
      end else if (stack_level == 0) begin
         r.empty_return = 1'b1;
      end else begin
         top = stack_level - 1;
         idx = frame_fn[top];
         elapsed_sum[idx] += ts - frame_t0[top];
         avg_elapsed[idx] = (hit_count[idx] == '0) ? '1
                          : elapsed_sum[idx] / {32'h0, hit_count[idx]};
         instr_sum[idx] += ic - frame_i0[top];
         stack_level = top;
      end
      if (!r.empty_return) begin
         r.entry_id     = ID_W'(idx);
         r.hit_total    = hit_count[idx];
         r.time_total   = elapsed_sum[idx];
         r.time_average = avg_elapsed[idx];
         r.instr_total  = instr_sum[idx];
      end
      r.all_calls = total_calls;
      return r;
   endfunction

   function automatic string describe(input profile_result_type r);
      return $sformatf("id=%h hits=%h t=%h avg=%h instr=%h calls=%h empty=%b full=%b",
                       r.entry_id, r.hit_total, r.time_total, r.time_average,
                       r.instr_total, r.all_calls, r.empty_return, r.stack_full);
   endfunction

   function automatic logic [VAL_W-1:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_request(input logic op, input logic [ID_W-1:0] fid,
                               input logic [VAL_W-1:0] ts, input logic [VAL_W-1:0] ic);
      bit taken;
      taken = 1'b0;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                             : $urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_func_id      <= fid;
      req_timestamp_ns <= ts;
      req_instr_count  <= ic;
      while (!taken) begin
         @(negedge clock);
         if (req_ready) begin
            taken = 1'b1;
            pending_results = {pending_results, profile_event(op, fid, ts, ic)};
         end
         @(posedge clock);
      end
   endtask

   // well-formed event: advance time and instruction counters, call or return per stack depth
   task automatic send_nested_event(input int call_pct);
      logic op;
      now_ns    += ($urandom_range(0, 19) == 0) ? {32'h0, $urandom()} : $urandom_range(0, 3000);
      now_instr += ($urandom_range(0, 19) == 0) ? {32'h0, $urandom()} : $urandom_range(0, 5000);
      if (stack_level == 0)
         op = OP_CALL;
      else if (stack_level >= STACK_DEPTH)
         op = ($urandom_range(0, 2) == 0) ? OP_CALL : OP_RETURN;
      else
         op = ($urandom_range(0, 99) < call_pct) ? OP_CALL : OP_RETURN;
      send_request(op, ($urandom_range(0, 1) == 0) ? ID_W'($urandom_range(0, 15))
                                                   : ID_W'($urandom()),
                   now_ns, now_instr);
   endtask

   task automatic test_directed_events();
      send_request(OP_RETURN, 8'hFF, '1, '1);
      send_request(OP_RETURN, 8'h00, '0, '0);
      send_request(OP_CALL,   8'h00, '0, '0);
      send_request(OP_CALL,   8'hFF, '1, '1);
      send_request(OP_RETURN, 8'h00, 64'h0, 64'h5);
      send_request(OP_RETURN, 8'h3C, 64'h8000_0000_0000_0000, 64'h0);
      send_request(OP_CALL,   8'hAA, 64'd100, 64'd1000);
      send_request(OP_CALL,   8'h55, 64'd200, 64'd2000);
      send_request(OP_CALL,   8'hAA, 64'd300, 64'd3000);
      send_request(OP_RETURN, 8'h11, 64'd350, 64'd3500);
      send_request(OP_RETURN, 8'h22, 64'd150, 64'd1500);
      send_request(OP_RETURN, 8'h7F, 64'd1000, 64'd9000);
      send_request(OP_RETURN, 8'h80, 64'd1100, 64'd9100);
      send_request(OP_CALL,   8'h01, 64'd5000, 64'd7000);
      send_request(OP_RETURN, 8'h01, 64'd5000, 64'd7000);
      send_request(OP_CALL,   8'h80, 64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_0000_0000);
      send_request(OP_RETURN, 8'h7F, 64'h0000_0000_0000_0010, 64'h0000_0001_0000_0000);
      now_ns    = rand64();
      now_instr = rand64();
   endtask

   task automatic test_stack_overflow();
      int k;
      while (stack_level < STACK_DEPTH)
         send_nested_event(100);
      for (k = 0; k < 3; k++) begin
         now_ns += $urandom_range(1, 500);
         send_request(OP_CALL, ID_W'($urandom()), now_ns, rand64());
      end
      while (stack_level > 0)
         send_nested_event(0);
      send_request(OP_RETURN, ID_W'($urandom()), rand64(), rand64());
      send_request(OP_RETURN, ID_W'($urandom()), rand64(), rand64());
   endtask

   task automatic test_output_backpressure();
      int k;
      hold_requests++;
      for (k = 0; k < 20; k++)
         send_nested_event(50);
   endtask

   task automatic test_random_nesting(input int count);
      int k;
      int call_pct;
      call_pct = 50;
      for (k = 0; k < count; k++) begin
         if (k % 150 == 0)
            case ($urandom_range(0, 3))
               0: call_pct = 30;
               1: call_pct = 50;
               2: call_pct = 65;
               default: call_pct = 85;
            endcase
         if ($urandom_range(0, 99) < 6)
            send_request(logic'($urandom_range(0, 1)), ID_W'($urandom()), rand64(), rand64());
         else
            send_nested_event(call_pct);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_events();
      test_stack_overflow();
      test_output_backpressure();
      test_random_nesting(1280);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // result receiver: stall patterns in phases, long hold on request
   initial begin : result_receiver
      int phase_len;
      int mode;
      int k;
      int holds_done;
      holds_done = 0;
      forever begin
         mode      = $urandom_range(0, 3);
         phase_len = $urandom_range(8, 60);
         for (k = 0; k < phase_len && hold_requests == holds_done; k++) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ((k % 4) != 3);
               default: rsp_ready <= ($urandom_range(0, 1) != 0);
            endcase
            @(posedge clock);
         end
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
      end
   end

   always @(negedge clock) begin : result_check
      profile_result_type seen;
      profile_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.entry_id     = rsp_entry_id;
         seen.hit_total    = rsp_hit_total;
         seen.time_total   = rsp_time_total;
         seen.time_average = rsp_time_average;
         seen.instr_total  = rsp_instr_total;
         seen.all_calls    = rsp_all_calls;
         seen.empty_return = rsp_empty_return;
         seen.stack_full   = rsp_stack_full;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected result: %s", describe(seen));
         end else begin
            want = pending_results.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("result mismatch at %0t", $realtime);
                  $display("  expected %s", describe(want));
                  $display("  actual   %s", describe(seen));
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/csfp_pkg.sv
rtl/call_stack_function_profiler_core.sv
rtl/csfp_checker.sv
tb/tb_top.sv
